// ----- design/kspb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Knight shortest path package
// Shared types, constants and the knight move table for the search block.
// ----------------------------------------------------------------------------
package kspb_pkg;

   // Field widths fixed by the interface.
   localparam int COORD_W   = 6;
   localparam int DIM_W     = 7;
   localparam int DIST_W    = 12;
   localparam int CSR_IDX_W = 2;

   // Default largest board side.
   localparam int MAX_DIM_DEF = 64;

   // Reset board size.
   localparam logic [DIM_W-1:0] DIM_RESET = 7'd8;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_BOARD_ROWS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BOARD_COLS = 2'd1;

   // Knight move offsets, one entry per move number.
   localparam logic signed [2:0] KNIGHT_DR [8] = '{
      3'sd2, 3'sd2, -3'sd2, -3'sd2, 3'sd1, 3'sd1, -3'sd1, -3'sd1};
   localparam logic signed [2:0] KNIGHT_DC [8] = '{
      -3'sd1, 3'sd1, -3'sd1, 3'sd1, -3'sd2, 3'sd2, -3'sd2, 3'sd2};

   // Request payload.
   typedef struct packed {
      logic [COORD_W-1:0] src_row;
      logic [COORD_W-1:0] src_col;
      logic [COORD_W-1:0] dst_row;
      logic [COORD_W-1:0] dst_col;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic              reachable;
      logic [DIST_W-1:0] move_count;
   } rsp_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SEED,
      ST_POP,
      ST_FETCH,
      ST_MOVE,
      ST_PROBE,
      ST_DONE
   } state_type;

endpackage

// ----- design/kspb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kspb_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/kspb_move_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Knight move unit
// Shared adder and bounds compare: applies one knight move to a square and
// tells whether the new square lies on the board.
// ----------------------------------------------------------------------------
module kspb_move_unit #(
   parameter int DW = 6
) (
   input  logic [DW-1:0]   cur_row,
   input  logic [DW-1:0]   cur_col,
   input  logic [2:0]      move_num,
   input  logic [DW:0]     rows,
   input  logic [DW:0]     cols,
   output logic [2*DW-1:0] nb_idx,
   output logic            on_board
);

   logic signed [DW+1:0] nr;
   logic signed [DW+1:0] nc;

   // Add the move offsets, then check both coordinates against the board.
   always_comb begin
      nr = $signed({2'b00, cur_row}) + (DW+2)'(kspb_pkg::KNIGHT_DR[move_num]);
      nc = $signed({2'b00, cur_col}) + (DW+2)'(kspb_pkg::KNIGHT_DC[move_num]);
      on_board = !nr[DW+1] && !nc[DW+1] && (nr[DW:0] < rows) && (nc[DW:0] < cols);
      nb_idx = {nr[DW-1:0], nc[DW-1:0]};
   end

endmodule

// ----- design/knight_shortest_path_bfs_unit.sv -----
`timescale 1ns / 1ps
// Each query clears the visited map (4096 cells at MAX_DIM 64), seeds the
// queue with the source, then for each dequeued square pops and fetches it,
// steps through the knight moves and probes the visited map for each on-board
// move. The unit takes one query at a time. Reset is synchronous and active
// high; it returns the sequencer to idle and the board size to 8 x 8.
// ----------------------------------------------------------------------------
// Knight shortest path search unit
// Breadth-first search over knight moves with a visited map and frontier
// queue held in RAM, driven by a small sequencer around one move unit.
// ----------------------------------------------------------------------------
module knight_shortest_path_bfs_unit #(
   parameter int MAX_DIM = kspb_pkg::MAX_DIM_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  kspb_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output kspb_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [kspb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kspb_pkg::DIM_W-1:0]         csr_data
);

   localparam int DW    = $clog2(MAX_DIM);
   localparam int AW    = 2 * DW;
   localparam int CELLS = 1 << AW;
   localparam int QW    = AW + kspb_pkg::DIST_W;

   kspb_pkg::state_type state_ff, state_in;

   logic [kspb_pkg::DIM_W-1:0]  rows_ff, cols_ff;
   kspb_pkg::req_type           req_ff;
   kspb_pkg::rsp_type           rsp_ff, rsp_in;
   logic [AW-1:0]               clr_ff, clr_in;
   logic [AW:0]                 head_ff, head_in, tail_ff, tail_in;
   logic [AW-1:0]               cur_idx_ff, cur_idx_in;
   logic [kspb_pkg::DIST_W-1:0] cur_dist_ff, cur_dist_in;
   logic [AW-1:0]               nb_ff, nb_in;
   logic [2:0]                  k_ff, k_in;

   // Clamped board size.
   logic [7:0]  rows_ext, cols_ext;
   logic [DW:0] rows_c, cols_c;
   logic [7:0]  sr8, sc8, dr8, dc8;
   logic        query_ok;
   logic [AW-1:0] src_idx, dst_idx;

   // RAM ports.
   logic          vis_we, vis_wdata, vis_rdata;
   logic [AW-1:0] vis_waddr, vis_raddr;
   logic          q_we;
   logic [AW-1:0] q_waddr, q_raddr;
   logic [QW-1:0] q_wdata, q_rdata;

   // Move unit.
   logic [AW-1:0] mv_idx;
   logic          mv_on;

   always_comb begin
      rows_ext = {1'b0, rows_ff};
      cols_ext = {1'b0, cols_ff};
      rows_c = (rows_ext > 8'(MAX_DIM)) ? (DW+1)'(MAX_DIM) : rows_ext[DW:0];
      cols_c = (cols_ext > 8'(MAX_DIM)) ? (DW+1)'(MAX_DIM) : cols_ext[DW:0];
      sr8 = {2'b00, req_ff.src_row};
      sc8 = {2'b00, req_ff.src_col};
      dr8 = {2'b00, req_ff.dst_row};
      dc8 = {2'b00, req_ff.dst_col};
      query_ok = (sr8 < 8'(rows_c)) && (sc8 < 8'(cols_c)) &&
                 (dr8 < 8'(rows_c)) && (dc8 < 8'(cols_c));
      src_idx = {sr8[DW-1:0], sc8[DW-1:0]};
      dst_idx = {dr8[DW-1:0], dc8[DW-1:0]};
   end

   kspb_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited (
      .clock   (clock),
      .wr_en   (vis_we),
      .wr_addr (vis_waddr),
      .wr_data (vis_wdata),
      .rd_addr (vis_raddr),
      .rd_data (vis_rdata)
   );

   kspb_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_queue (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (q_waddr),
      .wr_data (q_wdata),
      .rd_addr (q_raddr),
      .rd_data (q_rdata)
   );

   kspb_move_unit #(.DW(DW)) u_move (
      .cur_row  (cur_idx_ff[AW-1:DW]),
      .cur_col  (cur_idx_ff[DW-1:0]),
      .move_num (k_ff),
      .rows     (rows_c),
      .cols     (cols_c),
      .nb_idx   (mv_idx),
      .on_board (mv_on)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kspb_pkg::ST_IDLE:  if (req_valid) state_in = kspb_pkg::ST_CLEAR;
         kspb_pkg::ST_CLEAR: if (&clr_ff) state_in = kspb_pkg::ST_SEED;
         kspb_pkg::ST_SEED:  state_in = query_ok ? kspb_pkg::ST_POP : kspb_pkg::ST_DONE;
         kspb_pkg::ST_POP:   state_in = (head_ff == tail_ff) ? kspb_pkg::ST_DONE
                                                             : kspb_pkg::ST_FETCH;
         kspb_pkg::ST_FETCH: state_in = (q_rdata[QW-1:kspb_pkg::DIST_W] == dst_idx)
                                        ? kspb_pkg::ST_DONE : kspb_pkg::ST_MOVE;
         kspb_pkg::ST_MOVE: begin
            if (mv_on) state_in = kspb_pkg::ST_PROBE;
            else if (k_ff == 3'd7) state_in = kspb_pkg::ST_POP;
         end
         kspb_pkg::ST_PROBE: state_in = (k_ff == 3'd7) ? kspb_pkg::ST_POP
                                                       : kspb_pkg::ST_MOVE;
         kspb_pkg::ST_DONE:  if (!rsp_stall) state_in = kspb_pkg::ST_IDLE;
         default:            state_in = kspb_pkg::ST_IDLE;
      endcase
   end

   // Datapath and RAM controls.
   always_comb begin
      clr_in      = clr_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      cur_idx_in  = cur_idx_ff;
      cur_dist_in = cur_dist_ff;
      nb_in       = nb_ff;
      k_in        = k_ff;
      rsp_in      = rsp_ff;
      vis_we      = 1'b0;
      vis_waddr   = nb_ff;
      vis_wdata   = 1'b1;
      vis_raddr   = mv_idx;
      q_we        = 1'b0;
      q_waddr     = tail_ff[AW-1:0];
      q_wdata     = {nb_ff, kspb_pkg::DIST_W'(cur_dist_ff + 1'b1)};
      q_raddr     = head_ff[AW-1:0];
      case (state_ff)
         kspb_pkg::ST_IDLE: begin
            clr_in = '0;
         end
         kspb_pkg::ST_CLEAR: begin
            vis_we    = 1'b1;
            vis_waddr = clr_ff;
            vis_wdata = 1'b0;
            clr_in    = AW'(clr_ff + 1'b1);
         end
         kspb_pkg::ST_SEED: begin
            // Mark the source and place it first in the queue.
            rsp_in    = '0;
            vis_we    = query_ok;
            vis_waddr = src_idx;
            q_we      = query_ok;
            q_waddr   = '0;
            q_wdata   = {src_idx, kspb_pkg::DIST_W'(0)};
            head_in   = '0;
            tail_in   = (AW+1)'(1);
         end
         kspb_pkg::ST_FETCH: begin
            head_in     = (AW+1)'(head_ff + 1'b1);
            cur_idx_in  = q_rdata[QW-1:kspb_pkg::DIST_W];
            cur_dist_in = q_rdata[kspb_pkg::DIST_W-1:0];
            k_in        = '0;
            if (q_rdata[QW-1:kspb_pkg::DIST_W] == dst_idx) begin
               rsp_in.reachable  = 1'b1;
               rsp_in.move_count = q_rdata[kspb_pkg::DIST_W-1:0];
            end
         end
         kspb_pkg::ST_MOVE: begin
            nb_in = mv_idx;
            if (!mv_on) k_in = 3'(k_ff + 1'b1);
         end
         kspb_pkg::ST_PROBE: begin
            // Enqueue the neighbor when it is new.
            vis_we  = !vis_rdata;
            q_we    = !vis_rdata;
            if (!vis_rdata) tail_in = (AW+1)'(tail_ff + 1'b1);
            k_in    = 3'(k_ff + 1'b1);
         end
         default: begin
         end
      endcase
   end

   // Handshake outputs.
   always_comb begin
      req_stall = (state_ff != kspb_pkg::ST_IDLE);
      rsp_valid = (state_ff == kspb_pkg::ST_DONE);
      rsp_data  = rsp_ff;
      csr_ready = (state_ff == kspb_pkg::ST_IDLE);
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kspb_pkg::ST_IDLE;
         rows_ff  <= kspb_pkg::DIM_RESET;
         cols_ff  <= kspb_pkg::DIM_RESET;
         head_ff  <= '0;
         tail_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == kspb_pkg::REG_BOARD_ROWS) rows_ff <= csr_data;
            if (csr_index == kspb_pkg::REG_BOARD_COLS) cols_ff <= csr_data;
         end
      end
      if (state_ff == kspb_pkg::ST_IDLE && req_valid) req_ff <= req_data;
      clr_ff      <= clr_in;
      cur_idx_ff  <= cur_idx_in;
      cur_dist_ff <= cur_dist_in;
      nb_ff       <= nb_in;
      k_ff        <= k_in;
      rsp_ff      <= rsp_in;
   end

`ifndef SYNTH
   // The queue head never passes the tail.
   a_head_le_tail: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tail_ff) else $error("queue head passed tail");

   // An unreachable answer carries a zero move count.
   a_zero_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.reachable |-> rsp_data.move_count == '0)
      else $error("nonzero count on unreachable answer");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");
`endif

endmodule
